>>> rtl/rrts_pkg.sv
// Shared types and constants for the round-robin thread scheduler.
package rrts_pkg;

  localparam int unsigned ThreadSlotsDefault = 4;
  localparam int unsigned KindW  = 2;
  localparam int unsigned FuncW  = 16;
  localparam int unsigned ArgW   = 16;
  localparam int unsigned TickW  = 16;
  localparam logic [TickW-1:0] TickCompareReset = 16'd391;

  typedef enum logic [KindW-1:0] {
    KindTick   = 2'd0,
    KindButton = 2'd1,
    KindSpawn  = 2'd2,
    KindExit   = 2'd3
  } kind_e;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

>>> rtl/rrts_queue.sv
// Circular queue with push-then-pop in the same cycle, optionally reset full of 0..Depth-1.
module rrts_queue #(
  parameter int unsigned Depth    = 4,
  parameter int unsigned Width    = 2,
  parameter bit          InitFull = 1'b0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rrts_pkg::queue_ctrl_t  ctrl_i,
  input  logic [Width-1:0]       push_data_i,
  output logic [Width-1:0]       head_data_o,
  output rrts_pkg::queue_status_t status_o
);
  import rrts_pkg::*;

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(Depth);
  localparam logic [IdxW:0]   DepthExt = (IdxW + 1)'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [IdxW-1:0]  head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW:0]    tail_sum;
  logic [IdxW-1:0]  tail;
  logic             push_ok;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == FullCnt);

  assign push_ok  = ctrl_i.push && !status_o.full;
  assign tail_sum = {1'b0, head_q} + (IdxW + 1)'(count_q);
  assign tail     = (tail_sum >= DepthExt) ? IdxW'(tail_sum - DepthExt) : tail_sum[IdxW-1:0];

  // An empty queue hands the pushed beat straight to the head.
  assign head_data_o = status_o.empty ? push_data_i : mem_q[head_q];

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == LastIdx) ? '0 : head_q + 1'b1;
    end
    case ({push_ok, ctrl_i.pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= InitFull ? FullCnt : '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  if (InitFull) begin : g_init_full
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int i = 0; i < Depth; i++) begin
          mem_q[i] <= Width'(i);
        end
      end else if (push_ok) begin
        mem_q[tail] <= push_data_i;
      end
    end
  end else begin : g_init_empty
    always_ff @(posedge clk_i) begin
      if (push_ok) begin
        mem_q[tail] <= push_data_i;
      end
    end
  end

endmodule

>>> rtl/round_robin_thread_scheduler_top.sv
// Round-robin thread scheduler: event register, single-pass update, result register.
//
// One event (tick, button change, spawn, exit) is taken on every clock at which start is
// high; busy stays low. The event is registered, applied to the free list, the ready queue
// and the running id in a single pass, and its result appears on result_valid_o from the
// result register, for one cycle only: the receiver cannot stall it. A new event may be
// given every cycle. Id ThreadSlots is the initial program, which owns no slot and reports
// function and argument 0. Once a spawn finds no free slot or an exit finds the ready queue
// empty, panic_o stays high and further events change nothing. cfg_we_i writes the tick
// compare value; write it only while no event is in flight.
module round_robin_thread_scheduler_top #(
  parameter int unsigned ThreadSlots = rrts_pkg::ThreadSlotsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [rrts_pkg::KindW-1:0]           kind_i,
  input  logic                                 button_level_i,
  input  logic [rrts_pkg::FuncW-1:0]           function_handle_i,
  input  logic signed [rrts_pkg::ArgW-1:0]     argument_i,
  input  logic                                 cfg_we_i,
  input  logic [rrts_pkg::TickW-1:0]           cfg_data_i,
  output logic                                 result_valid_o,
  output logic [$clog2(ThreadSlots+1)-1:0]     running_thread_o,
  output logic [rrts_pkg::FuncW-1:0]           running_function_o,
  output logic signed [rrts_pkg::ArgW-1:0]     running_argument_o,
  output logic                                 switched_o,
  output logic [$clog2(ThreadSlots)-1:0]       spawned_slot_o,
  output logic                                 panic_o
);
  import rrts_pkg::*;

  localparam int unsigned IdW   = $clog2(ThreadSlots + 1);
  localparam int unsigned SlotW = $clog2(ThreadSlots);
  localparam logic [IdW-1:0] InitId = IdW'(ThreadSlots);

  // Event register
  logic              in_valid_q;
  kind_e             in_kind_q;
  logic              in_level_q;
  logic [FuncW-1:0]  in_func_q;
  logic [ArgW-1:0]   in_arg_q;

  // Scheduler state
  logic [TickW-1:0]  tick_cmp_q;
  logic [TickW-1:0]  tick_q, tick_d, tick_inc;
  logic [IdW-1:0]    current_q, current_d;
  logic              started_q, started_d;
  logic              halted_q, halted_d;
  logic [FuncW-1:0]  slot_func_q [ThreadSlots];
  logic [ArgW-1:0]   slot_arg_q  [ThreadSlots];
  logic              slot_we;

  // Queues
  queue_ctrl_t       rq_ctrl, fq_ctrl;
  queue_status_t     rq_status, fq_status;
  logic [IdW-1:0]    rq_push_data, rq_head;
  logic [SlotW-1:0]  fq_head;

  // Result register
  logic              res_valid_q;
  logic [IdW-1:0]    res_thread_q;
  logic [FuncW-1:0]  res_func_q, res_func_d;
  logic [ArgW-1:0]   res_arg_q, res_arg_d;
  logic              res_switched_q, res_switched_d;
  logic [SlotW-1:0]  res_spawned_q, res_spawned_d;
  logic              res_panic_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_kind_q  <= kind_e'(kind_i);
      in_level_q <= button_level_i;
      in_func_q  <= function_handle_i;
      in_arg_q   <= argument_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_cmp_q <= TickCompareReset;
    end else if (cfg_we_i) begin
      tick_cmp_q <= cfg_data_i;
    end
  end

  rrts_queue #(
    .Depth    (ThreadSlots + 1),
    .Width    (IdW),
    .InitFull (1'b0)
  ) u_ready_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (rq_ctrl),
    .push_data_i (rq_push_data),
    .head_data_o (rq_head),
    .status_o    (rq_status)
  );

  rrts_queue #(
    .Depth    (ThreadSlots),
    .Width    (SlotW),
    .InitFull (1'b1)
  ) u_free_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (fq_ctrl),
    .push_data_i (current_q[SlotW-1:0]),
    .head_data_o (fq_head),
    .status_o    (fq_status)
  );

  assign tick_inc = tick_q + 1'b1;

  always_comb begin
    rq_ctrl        = '0;
    fq_ctrl        = '0;
    rq_push_data   = current_q;
    current_d      = current_q;
    started_d      = started_q;
    halted_d       = halted_q;
    tick_d         = tick_q;
    slot_we        = 1'b0;
    res_switched_d = 1'b0;
    res_spawned_d  = '0;
    if (in_valid_q && !halted_q) begin
      case (in_kind_q)
        KindSpawn: begin
          if (!started_q) begin
            started_d = 1'b1;
            tick_d    = '0;
          end
          if (fq_status.empty) begin
            halted_d = 1'b1;
          end else begin
            fq_ctrl.pop   = 1'b1;
            slot_we       = 1'b1;
            rq_ctrl.push  = 1'b1;
            rq_push_data  = IdW'(fq_head);
            res_spawned_d = fq_head;
          end
        end
        KindTick: begin
          if (started_q) begin
            tick_d = tick_inc;
            if (tick_inc == tick_cmp_q) begin
              // Requeue the running id and take the head; an empty queue returns it.
              tick_d         = '0;
              rq_ctrl.push   = 1'b1;
              rq_ctrl.pop    = 1'b1;
              current_d      = rq_head;
              res_switched_d = 1'b1;
            end
          end
        end
        KindButton: begin
          if (started_q && !in_level_q) begin
            rq_ctrl.push   = 1'b1;
            rq_ctrl.pop    = 1'b1;
            current_d      = rq_head;
            res_switched_d = 1'b1;
          end
        end
        KindExit: begin
          if (started_q && (current_q < InitId)) begin
            fq_ctrl.push = !fq_status.full;
            if (rq_status.empty) begin
              halted_d = 1'b1;
            end else begin
              rq_ctrl.pop    = 1'b1;
              current_d      = rq_head;
              res_switched_d = 1'b1;
            end
          end
        end
        default: begin
          halted_d = halted_q;
        end
      endcase
    end
  end

  // A spawned slot is never the running one, so the old slot contents suffice here.
  always_comb begin
    if (current_d < InitId) begin
      res_func_d = slot_func_q[current_d[SlotW-1:0]];
      res_arg_d  = slot_arg_q[current_d[SlotW-1:0]];
    end else begin
      res_func_d = '0;
      res_arg_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      current_q   <= InitId;
      started_q   <= 1'b0;
      halted_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      tick_q      <= tick_d;
      current_q   <= current_d;
      started_q   <= started_d;
      halted_q    <= halted_d;
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_func_q[fq_head] <= in_func_q;
      slot_arg_q[fq_head]  <= in_arg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      res_thread_q   <= current_d;
      res_func_q     <= res_func_d;
      res_arg_q      <= res_arg_d;
      res_switched_q <= res_switched_d;
      res_spawned_q  <= res_spawned_d;
      res_panic_q    <= halted_d;
    end
  end

  assign result_valid_o     = res_valid_q;
  assign running_thread_o   = res_thread_q;
  assign running_function_o = res_func_q;
  assign running_argument_o = res_arg_q;
  assign switched_o         = res_switched_q;
  assign spawned_slot_o     = res_spawned_q;
  assign panic_o            = res_panic_q;

  // Every accepted beat yields exactly one result, through the event register and the result register.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 result_valid_o)
    else $error("result strobe missing after accepted event");

  // Halt is sticky.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag dropped");

  // A dispatch always finds a thread, so it never comes with a halt.
  a_switch_no_panic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && switched_o) |-> !panic_o)
    else $error("dispatch reported together with panic");

  // A spawn never dispatches.
  a_spawn_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (spawned_slot_o != '0)) |-> !switched_o)
    else $error("spawn reported a dispatch");

endmodule
